// ----- hw/rtl/bmpu_pkg.sv -----
// Shared types and constants for the bitmap pixel stream unpacker.
// No dependencies; every other file of the block imports this package.
package bmpu_pkg;

    // Widest row the block is built for, and the cap that applies to it.
    localparam int MAX_WIDTH       = 4096;
    localparam int WIDTH_CAP       = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4096;
    localparam int HEIGHT_CAP      = 4096;
    localparam int PALETTE_ENTRIES = 256;

    // Field widths of the channels and the configuration port.
    localparam int BYTE_W  = 8;
    localparam int CHAN_W  = 8;
    localparam int POS_W   = 12;
    localparam int DIM_W   = 13;
    localparam int CFG_W   = 13;
    localparam int CIDX_W  = 2;
    localparam int PCNT_W  = 10;
    localparam int PADR_W  = $clog2(PALETTE_ENTRIES);
    localparam int PENT_W  = 24;

    // Pixel depth codes.
    typedef enum logic [1:0] {
        DEPTH_8  = 2'd0,
        DEPTH_16 = 2'd1,
        DEPTH_24 = 2'd2,
        DEPTH_32 = 2'd3
    } t_depth;

    // Configuration register indexes.
    typedef enum logic [CIDX_W-1:0] {
        CFG_DEPTH  = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2,
        CFG_ICON   = 2'd3
    } t_cfg_reg;

    // Byte lanes of a palette entry as they arrive in the file.
    typedef enum logic [1:0] {
        LANE_BLUE  = 2'd0,
        LANE_GREEN = 2'd1,
        LANE_RED   = 2'd2,
        LANE_ALPHA = 2'd3
    } t_pal_lane;

endpackage

// ----- hw/rtl/bmpu_byte_if.sv -----
// Valid/ready channel that carries one bitmap data byte per transaction.
// Depends on bmpu_pkg for the field widths.
interface bmpu_byte_if;
    import bmpu_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              start_of_image;

    modport source (output valid, output data_byte, output start_of_image, input ready);
    modport sink   (input valid, input data_byte, input start_of_image, output ready);
endinterface

// ----- hw/rtl/bmpu_pixel_if.sv -----
// Valid/ready channel that carries one decoded RGBA pixel per transaction.
// Depends on bmpu_pkg for the field widths.
interface bmpu_pixel_if;
    import bmpu_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
    logic [POS_W-1:0]  column;
    logic [POS_W-1:0]  row;
    logic              last_pixel;

    modport source (output valid, output red, output green, output blue, output alpha,
                    output column, output row, output last_pixel, input ready);
    modport sink   (input valid, input red, input green, input blue, input alpha,
                    input column, input row, input last_pixel, output ready);
endinterface

// ----- hw/rtl/bmp_pixel_stream_unpacker_core.sv -----
// Top level of the bitmap pixel stream unpacker: palette memory, byte counters, output register.
// Depends on bmpu_pkg, bmpu_byte_if and bmpu_pixel_if.
//
//   Channel   Dir  Handshake        Payload
//   i_byte    in   valid / ready    data_byte, start_of_image
//   o_pixel   out  valid / ready    red, green, blue, alpha, column, row, last_pixel
//   cfg       in   i_cfg_we         i_cfg_index, i_cfg_data
//
// One byte is taken per cycle unless the input stalls; a pixel is presented in the cycle after its last byte.
// The palette memory is read in the cycle a palette pixel is accepted and its
// registered data drives the output directly, alongside the output register.
// The input stalls only while a finished pixel waits in the output register.
// Reset is synchronous; the palette memory is not cleared and holds garbage until loaded.
module bmp_pixel_stream_unpacker_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [bmpu_pkg::CIDX_W-1:0]  i_cfg_index,
    input  logic [bmpu_pkg::CFG_W-1:0]   i_cfg_data,
    bmpu_byte_if.sink                    i_byte,
    bmpu_pixel_if.source                 o_pixel
);
    import bmpu_pkg::*;

    // Configuration registers.
    t_depth             r_depth;
    logic [DIM_W-1:0]   r_width;
    logic [DIM_W-1:0]   r_height;
    logic               r_icon;

    // Stream state.
    logic               r_load, n_load;
    logic               r_fin, n_fin;
    logic [PCNT_W-1:0]  r_pcnt, n_pcnt;
    logic [1:0]         r_bip, n_bip;
    logic [PENT_W-1:0]  r_held, n_held;
    logic [POS_W-1:0]   r_col, n_col;
    logic [POS_W-1:0]   r_row, n_row;
    logic [1:0]         r_pad, n_pad;

    // Output register and palette read data.
    logic               r_ovalid;
    logic               r_is_pal;
    logic [CHAN_W-1:0]  r_red, r_green, r_blue, r_alpha;
    logic [POS_W-1:0]   r_ocol, r_orow;
    logic               r_olast;
    logic [PENT_W-1:0]  r_pal_q;

    // Palette memory: R in bits 7:0, G in 15:8, B in 23:16. Alpha is never read.
    logic [PENT_W-1:0]  palette_mem [PALETTE_ENTRIES];

    logic               acc;
    logic               emit;
    logic               pal_we;
    logic [PADR_W-1:0]  pal_waddr;
    t_pal_lane          pal_lane;
    logic [DIM_W-1:0]   eff_w, eff_h;
    logic               row_end;
    logic [1:0]         bpp_mod;
    logic [1:0]         row_bytes_mod;
    logic [CHAN_W-1:0]  p_red, p_green, p_blue, p_alpha;
    logic [BYTE_W-1:0]  b;

    assign b   = i_byte.data_byte;
    assign acc = i_byte.valid && i_byte.ready;
    assign i_byte.ready = !r_ovalid || o_pixel.ready;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth  <= DEPTH_24;
            r_width  <= DIM_W'(1);
            r_height <= DIM_W'(1);
            r_icon   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_DEPTH:  r_depth  <= t_depth'(i_cfg_data[1:0]);
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                CFG_ICON:   r_icon   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Saturated image dimensions.
    always_comb begin
        if (r_width == '0)
            eff_w = DIM_W'(1);
        else if (r_width > DIM_W'(WIDTH_CAP))
            eff_w = DIM_W'(WIDTH_CAP);
        else
            eff_w = r_width;
        if (r_height == '0)
            eff_h = DIM_W'(1);
        else if (r_height > DIM_W'(HEIGHT_CAP))
            eff_h = DIM_W'(HEIGHT_CAP);
        else
            eff_h = r_height;
    end

    // Row padding only needs the row size modulo four.
    assign bpp_mod       = 2'(r_depth) + 2'd1;
    assign row_bytes_mod = 2'(eff_w[1:0] * bpp_mod);

    // Decode of the accepted byte: start of image, palette load, padding,
    // partial pixel, complete pixel or a byte after the last pixel.
    always_comb begin
        n_load    = r_load;
        n_fin     = r_fin;
        n_pcnt    = r_pcnt;
        n_bip     = r_bip;
        n_held    = r_held;
        n_col     = r_col;
        n_row     = r_row;
        n_pad     = r_pad;
        emit      = 1'b0;
        pal_we    = 1'b0;
        pal_waddr = r_pcnt[PCNT_W-1:2];
        pal_lane  = t_pal_lane'(r_pcnt[1:0]);
        row_end   = 1'b0;

        if (i_byte.start_of_image) begin
            n_load = (r_depth == DEPTH_8);
            n_fin  = 1'b0;
            n_pcnt = '0;
            n_bip  = '0;
            n_held = '0;
            n_col  = '0;
            n_row  = POS_W'(eff_h - DIM_W'(1));
            n_pad  = '0;
        end

        pal_waddr = n_pcnt[PCNT_W-1:2];
        pal_lane  = t_pal_lane'(n_pcnt[1:0]);
        row_end   = ({1'b0, n_col} + DIM_W'(1)) >= eff_w;

        if (n_fin) begin
            // Bytes after the last pixel are dropped.
        end else if (n_load) begin
            pal_we = 1'b1;
            if (n_pcnt == '1) begin
                n_load = 1'b0;
                n_pcnt = '0;
            end else begin
                n_pcnt = n_pcnt + PCNT_W'(1);
            end
        end else if (n_pad != '0) begin
            n_pad = n_pad - 2'd1;
        end else if (n_bip < 2'(r_depth)) begin
            case (n_bip)
                2'd0: n_held[7:0]   = n_held[7:0]   | b;
                2'd1: n_held[15:8]  = n_held[15:8]  | b;
                2'd2: n_held[23:16] = n_held[23:16] | b;
                default: ;
            endcase
            n_bip = n_bip + 2'd1;
        end else begin
            emit   = 1'b1;
            n_held = '0;
            n_bip  = '0;
            if (row_end) begin
                n_col = '0;
                n_pad = 2'd0 - row_bytes_mod;
                if (n_row == '0)
                    n_fin = 1'b1;
                else
                    n_row = n_row - POS_W'(1);
            end else begin
                n_col = n_col + POS_W'(1);
            end
        end
    end

    // Pixel formatting for the direct-color depths and alpha for all depths.
    always_comb begin
        p_red   = b;
        p_green = r_held[15:8];
        p_blue  = r_held[7:0];
        p_alpha = 8'hFF;
        unique case (r_depth)
            DEPTH_8: begin
                if (r_icon && b == '0)
                    p_alpha = '0;
            end
            DEPTH_16: begin
                p_red   = {b[7:3], b[7:5]};
                p_green = {b[2:0], r_held[7:5], b[2:1]};
                p_blue  = {r_held[4:0], r_held[4:2]};
            end
            DEPTH_24: begin
                p_red = b;
            end
            DEPTH_32: begin
                p_red   = r_held[23:16];
                p_alpha = b;
            end
            default: ;
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load <= 1'b0;
            r_fin  <= 1'b0;
            r_pcnt <= '0;
            r_bip  <= '0;
            r_held <= '0;
            r_col  <= '0;
            r_row  <= '0;
            r_pad  <= '0;
        end else if (acc) begin
            r_load <= n_load;
            r_fin  <= n_fin;
            r_pcnt <= n_pcnt;
            r_bip  <= n_bip;
            r_held <= n_held;
            r_col  <= n_col;
            r_row  <= n_row;
            r_pad  <= n_pad;
        end
    end

    // Palette memory: byte-lane writes while loading, one registered read per palette pixel.
    always_ff @(posedge i_clk) begin
        if (acc && pal_we) begin
            case (pal_lane)
                LANE_BLUE:  palette_mem[pal_waddr][23:16] <= b;
                LANE_GREEN: palette_mem[pal_waddr][15:8]  <= b;
                LANE_RED:   palette_mem[pal_waddr][7:0]   <= b;
                default: ;
            endcase
        end
        if (acc && emit && r_depth == DEPTH_8)
            r_pal_q <= palette_mem[b];
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_ovalid <= 1'b0;
        else if (acc)
            r_ovalid <= emit;
        else if (o_pixel.ready)
            r_ovalid <= 1'b0;
    end

    // Output payload, loaded with each emitted pixel.
    always_ff @(posedge i_clk) begin
        if (acc && emit) begin
            r_is_pal <= (r_depth == DEPTH_8);
            r_red    <= p_red;
            r_green  <= p_green;
            r_blue   <= p_blue;
            r_alpha  <= p_alpha;
            r_ocol   <= i_byte.start_of_image ? '0 : r_col;
            r_orow   <= i_byte.start_of_image ? POS_W'(eff_h - DIM_W'(1)) : r_row;
            r_olast  <= row_end && (i_byte.start_of_image ? (eff_h == DIM_W'(1))
                                                          : (r_row == '0));
        end
    end

    // Palette pixels take their color from the memory read register.
    assign o_pixel.valid      = r_ovalid;
    assign o_pixel.red        = r_is_pal ? r_pal_q[7:0]   : r_red;
    assign o_pixel.green      = r_is_pal ? r_pal_q[15:8]  : r_green;
    assign o_pixel.blue       = r_is_pal ? r_pal_q[23:16] : r_blue;
    assign o_pixel.alpha      = r_alpha;
    assign o_pixel.column     = r_ocol;
    assign o_pixel.row        = r_orow;
    assign o_pixel.last_pixel = r_olast;

endmodule
